// ===== rtl/gacm_pkg.sv =====
// Shared types, constants and helpers for the grid agent collision move block.
package gacm_pkg;

    localparam int COORD_BITS = 12;
    localparam int IDX_BITS   = 8;
    localparam int ACT_BITS   = 9;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic signed [COORD_BITS+1:0] wide_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CH_DESIRED = 2'd0,
        CH_ALT_A   = 2'd1,
        CH_ALT_B   = 2'd2,
        CH_STAYED  = 2'd3
    } choice_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } cell_t;

    // index 0 desired, 1 first alternative, 2 second alternative
    typedef cell_t [2:0] cand_set_t;

    typedef struct packed {
        op_t                 operation;
        logic [IDX_BITS-1:0] agent_index;
        coord_t              coord_x;
        coord_t              coord_y;
    } req_item_t;

    typedef struct packed {
        coord_t  new_x;
        coord_t  new_y;
        choice_t choice;
    } rsp_item_t;

    function automatic coord_t sat_coord(input wide_t v);
        wide_t hi_w;
        wide_t lo_w;
        hi_w = wide_t'(COORD_MAX);
        lo_w = wide_t'(COORD_MIN);
        if (v > hi_w)
            return COORD_MAX;
        else if (v < lo_w)
            return COORD_MIN;
        else
            return coord_t'(v[COORD_BITS-1:0]);
    endfunction

endpackage

// ===== rtl/gacm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gacm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gacm_cand.sv =====
// Candidate builder: desired cell plus two alternatives, saturated to range.
module gacm_cand (
    input  gacm_pkg::cell_t     cur,
    input  gacm_pkg::cell_t     des,
    output gacm_pkg::cand_set_t cands
);
    import gacm_pkg::*;

    diff_t dx;
    diff_t dy;
    logic  straight;

    assign dx       = diff_t'(des.x) - diff_t'(cur.x);
    assign dy       = diff_t'(des.y) - diff_t'(cur.y);
    assign straight = (dx == diff_t'(0)) || (dy == diff_t'(0));

    always_comb
    begin
        cands[0] = des;
        if (straight)
        begin
            // sideways offsets
            cands[1].x = sat_coord(wide_t'(des.x) + wide_t'(dy));
            cands[1].y = sat_coord(wide_t'(des.y) + wide_t'(dx));
            cands[2].x = sat_coord(wide_t'(des.x) - wide_t'(dy));
            cands[2].y = sat_coord(wide_t'(des.y) - wide_t'(dx));
        end
        else
        begin
            // axis-aligned cells of a diagonal step
            cands[1].x = des.x;
            cands[1].y = cur.y;
            cands[2].x = cur.x;
            cands[2].y = des.y;
        end
    end

endmodule

// ===== rtl/gacm_near.sv =====
// Neighbor compare: flags candidates occupied by a nearby table entry.
module gacm_near (
    input  gacm_pkg::cell_t     entry,
    input  gacm_pkg::cell_t     mover,
    input  gacm_pkg::cand_set_t cands,
    output logic [2:0]          hit
);
    import gacm_pkg::*;

    diff_t dx;
    diff_t dy;
    logic  near;

    assign dx = diff_t'(entry.x) - diff_t'(mover.x);
    assign dy = diff_t'(entry.y) - diff_t'(mover.y);

    // squared distance below 4 <=> both offsets within one step
    assign near = (dx >= diff_t'(-1)) && (dx <= diff_t'(1))
               && (dy >= diff_t'(-1)) && (dy <= diff_t'(1));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hit[k] = near && (entry == cands[k]);
        end
    end

endmodule

// ===== rtl/grid_agent_collision_move.sv =====
// Top level: agent position table with collision-avoiding move sequencer.
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+----------------------------
//  req     | in        | req_item_t   | req_valid / req_ready
//  rsp     | out       | rsp_item_t   | rsp_valid / rsp_ready
//  cfg     | in        | active count | cfg_we, no wait, no read-back
//
// A load item writes the table in its accept cycle.
// A move item reads the mover, then builds candidates, then makes one table
// read per active entry (n = active count clamped to MAX_AGENTS) through the
// single RAM read port, then does the write-back.
// Reset clears control and the active count; the table itself is not cleared.
// A finished result waits in the output register; new items are taken
// meanwhile, and a later move holds in its last step until that slot frees.
module grid_agent_collision_move #(
    parameter int MAX_AGENTS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  gacm_pkg::req_item_t             req_item,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output gacm_pkg::rsp_item_t             rsp_item,
    input  logic                            cfg_we,
    input  logic [gacm_pkg::ACT_BITS-1:0]   cfg_wdata
);
    import gacm_pkg::*;

    localparam int AW     = $clog2(MAX_AGENTS);
    localparam int CNT_W  = $clog2(MAX_AGENTS + 1);
    localparam int CMP_W  = (CNT_W > ACT_BITS) ? CNT_W : ACT_BITS;
    localparam int MOD_W  = CNT_W + IDX_BITS;
    localparam int SH_W   = IDX_BITS + CNT_W;
    localparam int RCP_W  = IDX_BITS + 2;
    localparam int PROD_W = IDX_BITS + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((longint'(1) << SH_W) + longint'(MAX_AGENTS) - 1) / longint'(MAX_AGENTS));

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CAND,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [ACT_BITS-1:0]  act_reg, act_next;
    logic [AW-1:0]        idx_reg, idx_next;
    cell_t                des_reg, des_next;
    cell_t                mover_reg, mover_next;
    cand_set_t            cand_reg, cand_next;
    logic [2:0]           taken_reg, taken_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_item_reg, rsp_item_next;

    logic                 req_fire;
    logic [PROD_W-1:0]    quo_prod;
    logic [IDX_BITS-1:0]  quo;
    logic [MOD_W-1:0]     rem;
    logic [AW-1:0]        idx_mod;
    logic [CMP_W-1:0]     act_ext;
    logic [CNT_W-1:0]     n_cnt;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 out_free;
    choice_t              choice;
    cell_t                chosen;
    cand_set_t            cand_w;
    logic [2:0]           hit;
    cell_t                ram_rdata;
    logic [2*COORD_BITS-1:0] ram_rdata_raw;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    cell_t                ram_wdata;
    logic [AW-1:0]        ram_raddr;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign ram_rdata = cell_t'(ram_rdata_raw);
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // index wraps modulo the table depth: reciprocal multiply gives the
    // exact quotient for any index of IDX_BITS bits
    assign quo_prod = PROD_W'(req_item.agent_index) * PROD_W'(RECIP);
    assign quo      = IDX_BITS'(quo_prod >> SH_W);
    assign rem      = MOD_W'(req_item.agent_index) - MOD_W'(quo) * MOD_W'(MAX_AGENTS);
    assign idx_mod  = rem[AW-1:0];

    // active count clamped to the table depth
    assign act_ext = CMP_W'(act_reg);
    assign n_cnt   = (act_ext > CMP_W'(MAX_AGENTS)) ? CNT_W'(MAX_AGENTS)
                                                   : CNT_W'(act_ext);

    gacm_cand u_cand (
        .cur   (ram_rdata),
        .des   (des_reg),
        .cands (cand_w)
    );

    gacm_near u_near (
        .entry (ram_rdata),
        .mover (mover_reg),
        .cands (cand_reg),
        .hit   (hit)
    );

    // first free candidate wins
    always_comb
    begin
        if (!taken_reg[0])
        begin
            choice = CH_DESIRED;
            chosen = cand_reg[0];
        end
        else if (!taken_reg[1])
        begin
            choice = CH_ALT_A;
            chosen = cand_reg[1];
        end
        else if (!taken_reg[2])
        begin
            choice = CH_ALT_B;
            chosen = cand_reg[2];
        end
        else
        begin
            choice = CH_STAYED;
            chosen = mover_reg;
        end
    end

    // table write: loads at accept, moves at write-back (never both)
    always_comb
    begin
        if (state_reg == S_FINISH)
        begin
            ram_we    = out_free && (choice != CH_STAYED);
            ram_waddr = idx_reg;
            ram_wdata = chosen;
        end
        else
        begin
            ram_we    = req_fire && (req_item.operation == OP_LOAD);
            ram_waddr = idx_mod;
            ram_wdata = '{x: req_item.coord_x, y: req_item.coord_y};
        end
    end

    always_comb
    begin
        case (state_reg)
            S_CAND:  ram_raddr = '0;
            S_SCAN:  ram_raddr = cnt_inc[AW-1:0];
            default: ram_raddr = idx_reg;
        endcase
    end

    gacm_ram #(
        .WIDTH (2*COORD_BITS),
        .DEPTH (MAX_AGENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    always_comb
    begin
        state_next     = state_reg;
        act_next       = cfg_we ? cfg_wdata : act_reg;
        idx_next       = idx_reg;
        des_next       = des_reg;
        mover_next     = mover_reg;
        cand_next      = cand_reg;
        taken_next     = taken_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_item_next  = rsp_item_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req_item.operation == OP_MOVE))
                begin
                    idx_next   = idx_mod;
                    des_next   = '{x: req_item.coord_x, y: req_item.coord_y};
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CAND;
            end
            S_CAND:
            begin
                // mover position is on the read port now
                mover_next = ram_rdata;
                cand_next  = cand_w;
                taken_next = '0;
                cnt_next   = '0;
                state_next = (n_cnt == '0) ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                // entry cnt_reg is on the read port; next one is requested
                taken_next = taken_reg | hit;
                cnt_next   = cnt_inc;
                if (cnt_inc == n_cnt)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = '{new_x: chosen.x, new_y: chosen.y, choice: choice};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
            taken_reg     <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_item_reg  <= rsp_item_next;
            taken_reg     <= taken_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        des_reg      <= des_next;
        mover_reg    <= mover_next;
        cand_reg     <= cand_next;
    end

endmodule

// ===== rtl/gacm_chk.sv =====
// Port-level checker for the grid agent collision move block, with its bind.
module gacm_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input gacm_pkg::req_item_t           req_item,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input gacm_pkg::rsp_item_t           rsp_item,
    input logic                          cfg_we,
    input logic [gacm_pkg::ACT_BITS-1:0] cfg_wdata
);
    import gacm_pkg::*;

    logic move_fire;
    logic load_fire;

    assign move_fire = req_valid && req_ready && (req_item.operation == OP_MOVE);
    assign load_fire = req_valid && req_ready && (req_item.operation == OP_LOAD);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    // a move occupies the block: no new item right after it
    a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
        move_fire |=> !req_ready)
        else $error("item taken during a move");

    // a load finishes in its accept cycle
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> req_ready)
        else $error("load did not free the input");

    // a move result cannot appear before read and candidate steps
    a_move_latency: assert property (@(posedge clk) disable iff (!rst_n)
        move_fire |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
        else $error("move result too early");

    // active count changes only while the block is quiet
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> req_ready && !rsp_valid && !$isunknown(cfg_wdata))
        else $error("active count written while busy");

endmodule

bind grid_agent_collision_move gacm_chk u_gacm_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for grid_agent_collision_move: table predictor, paced traffic, per-field result checks.
module testbench;
    import gacm_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int NEAR_SQ     = 4;                 // squared neighbor radius
    localparam int SETTLE      = TABLE_DEPTH + 8;   // longest move plus margin

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_item_t           req_item;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_item_t           rsp_item;
    logic                cfg_we;
    logic [ACT_BITS-1:0] cfg_wdata;

    // Predictor state: our own copy of the position table and the active count.
    coord_t      agent_x [TABLE_DEPTH];
    coord_t      agent_y [TABLE_DEPTH];
    int unsigned live_count;

    // Predicted outcomes of accepted moves, oldest first.
    rsp_item_t   pending_moves [$];
    rsp_item_t   due_result;

    int error_count  = 0;
    int burst_left   = 0;
    int hold_request = 0;   // receiver picks this up and holds off that many cycles
    int hub_x        = 0;   // cluster center for the current stretch of traffic
    int hub_y        = 0;

    grid_agent_collision_move #(
        .MAX_AGENTS (TABLE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int clamp_coord(input int v);
        if (v > int'(COORD_MAX))
            return int'(COORD_MAX);
        if (v < int'(COORD_MIN))
            return int'(COORD_MIN);
        return v;
    endfunction

    // A cell is blocked only by an active agent sitting on it that is also
    // a close neighbor of the mover's current cell (the mover included).
    function automatic bit cell_blocked(input int tx, input int ty,
                                        input int mx, input int my, input int n);
        int j;
        int ox;
        int oy;
        bit hit;
        hit = 1'b0;
        for (j = 0; j < n; j++)
        begin
            ox = agent_x[j];
            oy = agent_y[j];
            if ((ox - mx) * (ox - mx) + (oy - my) * (oy - my) < NEAR_SQ &&
                ox == tx && oy == ty)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Works out where a move lands and updates the table copy.
    function automatic rsp_item_t move_outcome(input req_item_t it);
        int        idx;
        int        cx;
        int        cy;
        int        px;
        int        py;
        int        dx;
        int        dy;
        int        n;
        int        k;
        int        cand_x [3];
        int        cand_y [3];
        choice_t   picks [3];
        bit        placed;
        rsp_item_t r;
        idx = it.agent_index;
        cx  = agent_x[idx];
        cy  = agent_y[idx];
        px  = it.coord_x;
        py  = it.coord_y;
        n   = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : live_count;
        dx  = px - cx;
        dy  = py - cy;
        cand_x[0] = px;
        cand_y[0] = py;
        if (dx == 0 || dy == 0)
        begin
            // straight heading: sidestep across it, saturating at the grid edge
            cand_x[1] = clamp_coord(px + dy);
            cand_y[1] = clamp_coord(py + dx);
            cand_x[2] = clamp_coord(px - dy);
            cand_y[2] = clamp_coord(py - dx);
        end
        else
        begin
            // diagonal heading: try one axis at a time
            cand_x[1] = px;
            cand_y[1] = cy;
            cand_x[2] = cx;
            cand_y[2] = py;
        end
        picks[0] = CH_DESIRED;
        picks[1] = CH_ALT_A;
        picks[2] = CH_ALT_B;
        r.choice = CH_STAYED;
        placed   = 1'b0;
        for (k = 0; k < 3; k++)
        begin
            if (!placed && !cell_blocked(cand_x[k], cand_y[k], cx, cy, n))
            begin
                placed       = 1'b1;
                r.choice     = picks[k];
                agent_x[idx] = coord_t'(cand_x[k]);
                agent_y[idx] = coord_t'(cand_y[k]);
            end
        end
        r.new_x = agent_x[idx];
        r.new_y = agent_y[idx];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    function automatic req_item_t pack_item(input op_t op, input int idx,
                                            input int x, input int y);
        req_item_t it;
        it.operation   = op;
        it.agent_index = idx[IDX_BITS-1:0];
        it.coord_x     = coord_t'(x);
        it.coord_y     = coord_t'(y);
        return it;
    endfunction

    function automatic int near_coord(input int hub, input int spread);
        return clamp_coord(hub + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Mostly well-formed traffic inside the cluster: loads that pack agents
    // around the hub and short moves that run into neighbors. A few moves go
    // anywhere on the grid, and a few items are pure noise.
    function automatic req_item_t random_item(input int unsigned live);
        req_item_t it;
        int        idx;
        int        roll;
        int        reach;
        int        top;
        roll = $urandom_range(0, 99);
        top  = (live > TABLE_DEPTH) ? TABLE_DEPTH : live;
        if (top > 0 && $urandom_range(0, 9) != 0)
            idx = $urandom_range(0, top - 1);
        else
            idx = $urandom_range(0, TABLE_DEPTH - 1);
        if (roll < 22)
            it = pack_item(OP_LOAD, idx, near_coord(hub_x, 2), near_coord(hub_y, 2));
        else if (roll < 90)
        begin
            reach = (roll < 78) ? 1 : 3;
            it = pack_item(OP_MOVE, idx, near_coord(agent_x[idx], reach),
                           near_coord(agent_y[idx], reach));
        end
        else if (roll < 95)
            it = pack_item(OP_MOVE, idx, int'(coord_t'($urandom)), int'(coord_t'($urandom)));
        else
        begin
            it.operation   = op_t'($urandom_range(0, 1));
            it.agent_index = IDX_BITS'($urandom);
            it.coord_x     = coord_t'($urandom);
            it.coord_y     = coord_t'($urandom);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one item from a falling edge and holds it until accepted.
    // Valid stays high on return; pace() or wait_idle() lowers it.
    task automatic send_item(input req_item_t it);
        req_item  <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (it.operation == OP_LOAD)
        begin
            agent_x[it.agent_index] = it.coord_x;
            agent_y[it.agent_index] = it.coord_y;
        end
        else
            pending_moves.insert(pending_moves.size(), move_outcome(it));
        @(negedge clk);
    endtask

    // Bursts of back-to-back items with random gaps; now and then the gap
    // lasts until every outstanding move has reported.
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                while (pending_moves.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            else
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Quiet the request side, let every move report, then give a trailing
    // load time to land before anything else happens.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_active(input int unsigned value);
        wait_idle();
        cfg_wdata <= ACT_BITS'(value);
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        live_count = value % (1 << ACT_BITS);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Writes every table entry so that no later scan touches an unwritten
    // one. Four clusters, three of them jammed against grid corners.
    task automatic test_fill_table();
        int i;
        int hx [4];
        int hy [4];
        hx = '{0, int'(COORD_MAX), int'(COORD_MIN), int'(COORD_MIN)};
        hy = '{0, int'(COORD_MAX), int'(COORD_MIN), int'(COORD_MAX)};
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            send_item(pack_item(OP_LOAD, i, near_coord(hx[i % 4], 3),
                                near_coord(hy[i % 4], 3)));
            pace();
        end
    endtask

    task automatic test_directed_cases();
        write_active(6);
        // small neighborhood around the origin plus two corner agents
        send_item(pack_item(OP_LOAD, 0, 0, 0));
        send_item(pack_item(OP_LOAD, 1, 1, 0));
        send_item(pack_item(OP_LOAD, 2, 1, 1));
        send_item(pack_item(OP_LOAD, 3, 1, -1));
        send_item(pack_item(OP_LOAD, 4, int'(COORD_MAX), int'(COORD_MAX)));
        send_item(pack_item(OP_LOAD, 5, int'(COORD_MIN), int'(COORD_MIN)));
        // desired and both sidesteps occupied: stays
        send_item(pack_item(OP_MOVE, 0, 1, 0));
        // free the second sidestep
        send_item(pack_item(OP_LOAD, 3, 40, 40));
        send_item(pack_item(OP_MOVE, 0, 1, 0));
        // desired is its own cell while active: stays
        send_item(pack_item(OP_MOVE, 0, 1, -1));
        // occupant two cells away is not a neighbor, so the cell is free
        send_item(pack_item(OP_LOAD, 1, 3, -1));
        send_item(pack_item(OP_MOVE, 0, 3, -1));
        // diagonal onto a neighbor: falls back to the x-only cell
        send_item(pack_item(OP_LOAD, 1, 2, 2));
        send_item(pack_item(OP_MOVE, 2, 2, 2));
        // top corner: second sidestep would leave the grid and saturates
        // back onto the occupied desired cell
        send_item(pack_item(OP_LOAD, 3, int'(COORD_MAX), int'(COORD_MAX) - 1));
        send_item(pack_item(OP_LOAD, 1, int'(COORD_MAX) - 1, int'(COORD_MAX) - 1));
        send_item(pack_item(OP_MOVE, 4, int'(COORD_MAX), int'(COORD_MAX) - 1));
        // same at the bottom corner
        send_item(pack_item(OP_LOAD, 3, int'(COORD_MIN), int'(COORD_MIN) + 1));
        send_item(pack_item(OP_LOAD, 2, int'(COORD_MIN) + 1, int'(COORD_MIN) + 1));
        send_item(pack_item(OP_MOVE, 5, int'(COORD_MIN), int'(COORD_MIN) + 1));
        // full-range diagonal jump
        send_item(pack_item(OP_MOVE, 5, int'(COORD_MAX), int'(COORD_MAX)));
        // inactive mover does not block its own cell
        send_item(pack_item(OP_LOAD, 255, 100, 100));
        send_item(pack_item(OP_MOVE, 255, 100, 100));
        // nobody active: nothing blocks
        write_active(0);
        send_item(pack_item(OP_MOVE, 0, agent_x[0], agent_y[0]));
        // count above the table size clamps, so entry 255 now blocks itself
        write_active(511);
        send_item(pack_item(OP_MOVE, 255, 100, 100));
    endtask

    // Receiver holds off for a long stretch while moves keep coming, so the
    // output slot fills and the block stops taking items.
    task automatic test_output_stall();
        int i;
        write_active(4);
        for (i = 0; i < 4; i++)
            send_item(pack_item(OP_LOAD, i, near_coord(0, 1), near_coord(0, 1)));
        hold_request = 700;
        for (i = 0; i < 12; i++)
            send_item(pack_item(OP_MOVE, i % 4, near_coord(agent_x[i % 4], 1),
                                near_coord(agent_y[i % 4], 1)));
    endtask

    // Random traffic over a spread of active counts, each around its own hub.
    task automatic test_random_phases();
        int unsigned lives [10];
        int          p;
        lives = '{1, 8, 3, 64, 256, 16, 511, 2, 0, 200};
        for (p = 0; p < 10; p++)
        begin
            write_active(lives[p]);
            case ($urandom_range(0, 3))
                0: begin hub_x = 0; hub_y = 0; end
                1: begin hub_x = int'(COORD_MAX); hub_y = int'(COORD_MAX); end
                2: begin hub_x = int'(COORD_MIN); hub_y = int'(COORD_MAX); end
                default:
                begin
                    hub_x = int'(coord_t'($urandom));
                    hub_y = int'(coord_t'($urandom));
                end
            endcase
            repeat (88)
            begin
                send_item(random_item(lives[p]));
                pace();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_item   = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        live_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_table();
        test_directed_cases();
        test_output_stall();
        test_random_phases();

        // everything accepted; let the last results drain and watch for strays
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Stall patterns change at random intervals; a requested hold-off
    // overrides them and is counted down here.
    initial
    begin
        rx_mode_e rx_mode;
        int       rx_left;
        int       hold_left;
        int       beat;
        rsp_ready = 1'b0;
        rx_mode   = RX_OPEN;
        rx_left   = 0;
        hold_left = 0;
        beat      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_e'($urandom_range(0, 3));
                    rx_left = $urandom_range(20, 200);
                end
                rx_left--;
                beat++;
                case (rx_mode)
                    RX_OPEN:   rsp_ready <= 1'b1;
                    RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ready <= ((beat % 5) < 3);
                endcase
            end
        end
    end

    task automatic note_mismatch(input string field, input int want, input int got);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Every accepted result is matched against the oldest predicted move.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_moves.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual x=%0d y=%0d choice=%0d",
                         $time, rsp_item.new_x, rsp_item.new_y, rsp_item.choice);
            end
            else
            begin
                due_result = pending_moves.pop_front();
                if (rsp_item.new_x !== due_result.new_x)
                    note_mismatch("new_x", due_result.new_x, rsp_item.new_x);
                if (rsp_item.new_y !== due_result.new_y)
                    note_mismatch("new_y", due_result.new_y, rsp_item.new_y);
                if (rsp_item.choice !== due_result.choice)
                    note_mismatch("choice", due_result.choice, rsp_item.choice);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
